>>> rtl/text_console_cursor_control_core_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor control: assertion macros
// Shared property checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TCCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TCCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCCC_ASSERT_IMP(lbl, ante, cons, msg)
`define TCCC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/tccc_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor control package
// Character codes, the wrap limit, the reset prompt width and the result record shared by the modules.
// ----------------------------------------------------------------------------
package tccc_pkg;

    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [5:0] WRAP_MAX       = 6'd63;
    localparam logic [5:0] PROMPT_RESET   = 6'd2;

    typedef struct packed {
        logic       write_enable;
        logic [5:0] write_row;
        logic [5:0] write_col;
        logic [7:0] write_data;
        logic       clear_row_enable;
        logic [5:0] clear_row_index;
        logic [5:0] display_top_row;
    } result_t;

endpackage

>>> rtl/text_console_cursor_control_core.sv
// ----------------------------------------------------------------------------
// Text console cursor control core
// Turns a stream of character codes into cell writes and scroll commands.
// ----------------------------------------------------------------------------
// One character transaction is accepted per clock cycle while the consumer
// takes results. The input register captures the character at the accepting
// edge, and the cursor update loads the result register from it as soon as
// that register has room. The cursor update is a single pass of counter
// logic, so back-to-back characters keep full rate as long as the consumer
// takes results. Backspace (8) erases left of the cursor, newline (10) starts
// a new line, and every other code is stored at the cursor. prompt_width may
// be written only while no transaction is in flight.
module text_console_cursor_control_core #(
    parameter int COLS     = 64,
    parameter int ROWS     = 32,
    parameter int MEM_ROWS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_enable,
    input  logic [5:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_enable,
    output logic [5:0] write_row,
    output logic [5:0] write_col,
    output logic [7:0] write_data,
    output logic       clear_row_enable,
    output logic [5:0] clear_row_index,
    output logic [5:0] display_top_row
);

    logic              item_valid;
    logic [7:0]        item_code;
    logic              room;
    logic              step;
    tccc_pkg::result_t result;
    tccc_pkg::result_t result_out;

    assign step = item_valid && room;

    tccc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .consume    (step),
        .item_valid (item_valid),
        .item_code  (item_code)
    );

    tccc_cursor #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .MEM_ROWS (MEM_ROWS)
    ) u_cursor (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .step             (step),
        .code             (item_code),
        .result           (result)
    );

    tccc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (result),
        .room       (room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign write_enable     = result_out.write_enable;
    assign write_row        = result_out.write_row;
    assign write_col        = result_out.write_col;
    assign write_data       = result_out.write_data;
    assign clear_row_enable = result_out.clear_row_enable;
    assign clear_row_index  = result_out.clear_row_index;
    assign display_top_row  = result_out.display_top_row;

endmodule

>>> rtl/tccc_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one character transaction and holds it until the cursor logic
// consumes it.
// ----------------------------------------------------------------------------
module tccc_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       consume,
    output logic       item_valid,
    output logic [7:0] item_code
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] code_reg;

    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= char_code;
        end
    end

    assign item_valid = valid_reg;
    assign item_code  = code_reg;

endmodule

>>> rtl/tccc_cursor.sv
// ----------------------------------------------------------------------------
// Cursor state and update logic
// Holds cursor row and column, screen row, soft wrap count, window top row
// and the prompt width, and works out the cell write, row clear and window top for one character.
// ----------------------------------------------------------------------------
`include "text_console_cursor_control_core_defines.svh"

module tccc_cursor #(
    parameter int COLS     = 64,
    parameter int ROWS     = 32,
    parameter int MEM_ROWS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_enable,
    input  logic [5:0]       cfg_write_data,
    input  logic             step,
    input  logic [7:0]       code,
    output tccc_pkg::result_t result
);

    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(MEM_ROWS);
    localparam int SW = $clog2(ROWS);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] COL_LAST    = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_LAST    = RW'(MEM_ROWS - 1);
    localparam logic [SW-1:0] SCREEN_LAST = SW'(ROWS - 1);

    logic [CW-1:0] cursor_col_reg, cursor_col_next;
    logic [RW-1:0] cursor_row_reg, cursor_row_next;
    logic [SW-1:0] screen_row_reg, screen_row_next;
    logic [5:0]    soft_wrap_count_reg, soft_wrap_count_next;
    logic [RW-1:0] top_row_reg, top_row_next;
    logic [5:0]    prompt_width_reg;

    logic [RW-1:0] row_inc, row_dec, top_inc, top_dec;

    assign row_inc = (cursor_row_reg == ROW_LAST) ? '0 : cursor_row_reg + 1'b1;
    assign row_dec = (cursor_row_reg == '0) ? ROW_LAST : cursor_row_reg - 1'b1;
    assign top_inc = (top_row_reg == ROW_LAST) ? '0 : top_row_reg + 1'b1;
    assign top_dec = (top_row_reg == '0) ? ROW_LAST : top_row_reg - 1'b1;

    always_comb
    begin
        cursor_col_next      = cursor_col_reg;
        cursor_row_next      = cursor_row_reg;
        screen_row_next      = screen_row_reg;
        soft_wrap_count_next = soft_wrap_count_reg;
        top_row_next         = top_row_reg;
        result               = '0;

        if (step)
        begin
            case (code)
                tccc_pkg::CODE_BACKSPACE:
                begin
                    if (soft_wrap_count_reg != '0)
                    begin
                        if (cursor_col_reg == '0)
                        begin
                            if (screen_row_reg == '0)
                            begin
                                // At the top of the screen the window backs up with the cursor.
                                if (cursor_row_reg != '0)
                                begin
                                    top_row_next    = top_dec;
                                    cursor_row_next = row_dec;
                                    cursor_col_next = COL_LAST;
                                end
                            end
                            else
                            begin
                                cursor_row_next = row_dec;
                                screen_row_next = screen_row_reg - 1'b1;
                                cursor_col_next = COL_LAST;
                            end
                            soft_wrap_count_next = soft_wrap_count_reg - 1'b1;
                        end
                        else
                        begin
                            cursor_col_next = cursor_col_reg - 1'b1;
                        end
                    end
                    else if (PW'(cursor_col_reg) > PW'(prompt_width_reg))
                    begin
                        cursor_col_next = cursor_col_reg - 1'b1;
                    end
                    result.write_enable = 1'b1;
                    result.write_row    = 6'(cursor_row_next);
                    result.write_col    = 6'(cursor_col_next);
                end
                tccc_pkg::CODE_NEWLINE:
                begin
                    soft_wrap_count_next = '0;
                    cursor_col_next      = '0;
                    cursor_row_next      = row_inc;
                    if (screen_row_reg == SCREEN_LAST)
                    begin
                        top_row_next            = top_inc;
                        result.clear_row_enable = 1'b1;
                        result.clear_row_index  = 6'(row_inc);
                    end
                    else
                    begin
                        screen_row_next = screen_row_reg + 1'b1;
                    end
                end
                default:
                begin
                    result.write_enable = 1'b1;
                    result.write_row    = 6'(cursor_row_reg);
                    result.write_col    = 6'(cursor_col_reg);
                    result.write_data   = code;
                    if (cursor_col_reg == COL_LAST)
                    begin
                        if (soft_wrap_count_reg != tccc_pkg::WRAP_MAX)
                        begin
                            soft_wrap_count_next = soft_wrap_count_reg + 1'b1;
                        end
                        cursor_col_next = '0;
                        cursor_row_next = row_inc;
                        if (screen_row_reg == SCREEN_LAST)
                        begin
                            top_row_next            = top_inc;
                            result.clear_row_enable = 1'b1;
                            result.clear_row_index  = 6'(row_inc);
                        end
                        else
                        begin
                            screen_row_next = screen_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cursor_col_next = cursor_col_reg + 1'b1;
                    end
                end
            endcase
        end

        result.display_top_row = 6'(top_row_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg      <= '0;
            cursor_row_reg      <= '0;
            screen_row_reg      <= '0;
            soft_wrap_count_reg <= '0;
            top_row_reg         <= '0;
            prompt_width_reg    <= tccc_pkg::PROMPT_RESET;
        end
        else
        begin
            cursor_col_reg      <= cursor_col_next;
            cursor_row_reg      <= cursor_row_next;
            screen_row_reg      <= screen_row_next;
            soft_wrap_count_reg <= soft_wrap_count_next;
            top_row_reg         <= top_row_next;
            if (cfg_write_enable)
            begin
                prompt_width_reg <= cfg_write_data;
            end
        end
    end

    `TCCC_ASSERT_IMP(a_screen_row_bound, 1'b1, screen_row_reg <= SCREEN_LAST,
        "screen row beyond last screen row")
    `TCCC_ASSERT_IMP(a_cursor_row_bound, 1'b1, cursor_row_reg <= ROW_LAST,
        "cursor row beyond memory")
    `TCCC_ASSERT_NXT(a_newline_col_zero, step && (code == tccc_pkg::CODE_NEWLINE),
        (cursor_col_reg == '0) && (soft_wrap_count_reg == '0),
        "newline did not return to column zero")

endmodule

>>> rtl/tccc_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module tccc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tccc_pkg::result_t result_in,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output tccc_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    tccc_pkg::result_t result_reg;

    assign room       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

>>> dv/tccc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor control checker
// Watches the character and result channels, predicts every cell write,
// row clear and window position, and compares each result in order.
// ----------------------------------------------------------------------------
module tccc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_enable,
    input  logic [5:0] cfg_write_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       write_enable,
    input  logic [5:0] write_row,
    input  logic [5:0] write_col,
    input  logic [7:0] write_data,
    input  logic       clear_row_enable,
    input  logic [5:0] clear_row_index,
    input  logic [5:0] display_top_row,
    output int         mismatch_count,
    output int         pending_count,
    output int         result_count
);

    localparam logic [5:0] LAST_COL        = 6'd63;
    localparam logic [4:0] LAST_SCREEN_ROW = 5'd31;

    // Cursor state as the block should hold it. The memory row counters are
    // six bits wide, so they wrap at 64 rows on their own.
    logic [5:0] prompt_q  = tccc_pkg::PROMPT_RESET;
    logic [5:0] cur_row   = '0;
    logic [5:0] cur_col   = '0;
    logic [4:0] scr_row   = '0;
    logic [5:0] wrap_cnt  = '0;
    logic [5:0] top_q     = '0;

    tccc_pkg::result_t predicted_q[$];

    // Moves the cursor to column 0 of the next row; returns 1 on a scroll.
    function automatic logic next_line();
        cur_col = '0;
        cur_row = cur_row + 6'd1;
        if (scr_row == LAST_SCREEN_ROW) begin
            top_q = top_q + 6'd1;
            return 1'b1;
        end
        scr_row = scr_row + 5'd1;
        return 1'b0;
    endfunction

    function automatic tccc_pkg::result_t predict_char(input logic [7:0] code);
        tccc_pkg::result_t r;
        logic              scrolled;
        r        = '0;
        scrolled = 1'b0;
        if (code == tccc_pkg::CODE_BACKSPACE) begin
            if (wrap_cnt != 6'd0) begin
                if (cur_col == 6'd0) begin
                    // Step back onto the last column of the wrapped row, pulling
                    // the window up when the cursor is already on the top line.
                    if (scr_row == 5'd0) begin
                        if (cur_row != 6'd0) begin
                            top_q   = top_q - 6'd1;
                            cur_row = cur_row - 6'd1;
                            cur_col = LAST_COL;
                        end
                    end else begin
                        cur_row = cur_row - 6'd1;
                        scr_row = scr_row - 5'd1;
                        cur_col = LAST_COL;
                    end
                    wrap_cnt = wrap_cnt - 6'd1;
                end else begin
                    cur_col = cur_col - 6'd1;
                end
            end else if (cur_col > prompt_q) begin
                cur_col = cur_col - 6'd1;
            end
            r.write_enable = 1'b1;
            r.write_row    = cur_row;
            r.write_col    = cur_col;
            r.write_data   = 8'd0;
        end else if (code == tccc_pkg::CODE_NEWLINE) begin
            wrap_cnt = '0;
            scrolled = next_line();
        end else begin
            r.write_enable = 1'b1;
            r.write_row    = cur_row;
            r.write_col    = cur_col;
            r.write_data   = code;
            if (cur_col == LAST_COL) begin
                if (wrap_cnt < tccc_pkg::WRAP_MAX)
                    wrap_cnt = wrap_cnt + 6'd1;
                scrolled = next_line();
            end else begin
                cur_col = cur_col + 6'd1;
            end
        end
        if (scrolled) begin
            r.clear_row_enable = 1'b1;
            r.clear_row_index  = cur_row;
        end
        r.display_top_row = top_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        tccc_pkg::result_t got;
        tccc_pkg::result_t want;
        if (!rst_n) begin
            prompt_q       = tccc_pkg::PROMPT_RESET;
            cur_row        = '0;
            cur_col        = '0;
            scr_row        = '0;
            wrap_cnt       = '0;
            top_q          = '0;
            predicted_q.delete();
            mismatch_count = 0;
            pending_count  = 0;
            result_count   = 0;
        end else begin
            if (cfg_write_enable)
                prompt_q = cfg_write_data;
            // The result side is handled first: a result never belongs to a
            // character accepted in the same cycle.
            if (out_valid && out_ready) begin
                got = {write_enable, write_row, write_col, write_data,
                       clear_row_enable, clear_row_index, display_top_row};
                result_count++;
                if (predicted_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result transaction with none expected, actual",
                             $time, " we=%0d row=%0d col=%0d data=%0d clr=%0d idx=%0d top=%0d",
                             got.write_enable, got.write_row, got.write_col,
                             got.write_data, got.clear_row_enable, got.clear_row_index,
                             got.display_top_row);
                end else begin
                    want = predicted_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: mismatch, expected", $time,
                                 " we=%0d row=%0d col=%0d data=%0d clr=%0d idx=%0d top=%0d",
                                 want.write_enable, want.write_row, want.write_col,
                                 want.write_data, want.clear_row_enable,
                                 want.clear_row_index, want.display_top_row,
                                 ", actual we=%0d row=%0d col=%0d data=%0d clr=%0d",
                                 got.write_enable, got.write_row, got.write_col,
                                 got.write_data, got.clear_row_enable,
                                 " idx=%0d top=%0d", got.clear_row_index,
                                 got.display_top_row);
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_q.push_back(predict_char(char_code));
            pending_count = predicted_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor control testbench
// Feeds character streams with random stalls on both channels, changes the
// prompt width between phases and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_CHARS   = 110;
    localparam int SWEEP_GLYPHS  = 64 * 3;
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write_enable;
    logic [5:0] cfg_write_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_code;
    logic       out_valid;
    logic       out_ready;
    logic       write_enable;
    logic [5:0] write_row;
    logic [5:0] write_col;
    logic [7:0] write_data;
    logic       clear_row_enable;
    logic [5:0] clear_row_index;
    logic [5:0] display_top_row;

    int mismatch_count;
    int pending_count;
    int result_count;
    int chars_sent     = 0;
    int config_writes  = 0;
    int send_gap_pct   = 0;
    int ready_gap_pct  = 0;

    text_console_cursor_control_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .char_code        (char_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_enable     (write_enable),
        .write_row        (write_row),
        .write_col        (write_col),
        .write_data       (write_data),
        .clear_row_enable (clear_row_enable),
        .clear_row_index  (clear_row_index),
        .display_top_row  (display_top_row)
    );

    tccc_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .char_code        (char_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_enable     (write_enable),
        .write_row        (write_row),
        .write_col        (write_col),
        .write_data       (write_data),
        .clear_row_enable (clear_row_enable),
        .clear_row_index  (clear_row_index),
        .display_top_row  (display_top_row),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count),
        .result_count     (result_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] rand_glyph();
        logic [7:0] c;
        c = 8'($urandom_range(255, 0));
        while (c == tccc_pkg::CODE_BACKSPACE || c == tccc_pkg::CODE_NEWLINE)
            c = 8'($urandom_range(255, 0));
        return c;
    endfunction

    function automatic int pick_gap_pct();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transaction, with valid still high so back-to-back characters flow.
    task automatic send_char(input logic [7:0] code);
        int gap;
        if (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
            gap      = $urandom_range(3, 1);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = code;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_line(input int glyphs, input int erases);
        repeat (glyphs) send_char(rand_glyph());
        repeat (erases) send_char(tccc_pkg::CODE_BACKSPACE);
        send_char(tccc_pkg::CODE_NEWLINE);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_prompt(input logic [5:0] width);
        drain_results();
        cfg_write_enable = 1'b1;
        cfg_write_data   = width;
        @(negedge clk);
        cfg_write_enable = 1'b0;
        config_writes++;
    endtask

    // Result side stalls in short bursts.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (ready_gap_pct != 0 && $urandom_range(99, 0) < ready_gap_pct) begin
                out_ready = 1'b0;
                repeat ($urandom_range(3, 1) - 1) @(negedge clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: cycle limit reached with %0d results pending", $time, pending_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int         phase;
        int         phase_start;
        int         roll;
        int         len;
        bit         paused;
        logic [5:0] width;

        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        char_code        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: all three kinds of code, byte extremes, the prompt stop at
        // the reset width and at width zero.
        send_gap_pct  = 15;
        ready_gap_pct = 15;
        send_char(tccc_pkg::CODE_BACKSPACE);
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'hFF);
        repeat (3) send_char(tccc_pkg::CODE_BACKSPACE);
        send_char(tccc_pkg::CODE_NEWLINE);
        send_char(8'h01);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(8'hFE);
        write_prompt(6'd0);
        repeat (5) send_char(tccc_pkg::CODE_BACKSPACE);
        send_char(8'h55);
        send_char(8'hAA);
        send_char(tccc_pkg::CODE_NEWLINE);

        // The cursor is on screen row 2 here, so 31 newlines scroll the window
        // twice. A line then soft-wraps three times on the bottom row, scrolling
        // each time, and is erased back across its wraps to column 0.
        repeat (31) send_char(tccc_pkg::CODE_NEWLINE);
        repeat (SWEEP_GLYPHS) send_char(rand_glyph());
        repeat (SWEEP_GLYPHS + 8) send_char(tccc_pkg::CODE_BACKSPACE);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       width = 6'd0;
                1:       width = 6'd63;
                2:       width = tccc_pkg::PROMPT_RESET;
                default: width = 6'($urandom_range(63, 0));
            endcase
            write_prompt(width);
            if (phase == RANDOM_PHASES - 1) begin
                send_gap_pct  = 0;
                ready_gap_pct = 0;
            end else begin
                send_gap_pct  = pick_gap_pct();
                ready_gap_pct = pick_gap_pct();
            end
            phase_start = chars_sent;
            paused      = 1'b0;
            while (chars_sent - phase_start < PHASE_CHARS)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 65) begin
                    len = $urandom_range(20, 0);
                    send_line(len, $urandom_range(len + 4, 0));
                end else if (roll < 85) begin
                    len = $urandom_range(100, 40);
                    send_line(len, $urandom_range(len + 40, 0));
                end else begin
                    repeat ($urandom_range(8, 1)) send_char(8'($urandom_range(255, 0)));
                end
                if (!paused && chars_sent - phase_start >= PHASE_CHARS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d characters and checked %0d results under %0d prompt widths,",
                 chars_sent, result_count, config_writes + 1);
        $display("including a line wrapped three times on the bottom row and erased back.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
